// ===== rtl/three_phase_bridge_duty_generator_macros.svh =====
// Assertion macros for the three-phase bridge duty generator.
`ifndef THREE_PHASE_BRIDGE_DUTY_GENERATOR_MACROS_SVH
`define THREE_PHASE_BRIDGE_DUTY_GENERATOR_MACROS_SVH

// The condition holds at an edge, so the consequence holds at the next edge.
`define TPBD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("Assertion failed: next-cycle property.");

// The condition holds at an edge, so the consequence holds at the same edge.
`define TPBD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("Assertion failed: same-cycle property.");

`endif

// ===== rtl/tpbd_pkg.sv =====
// Shared types, constants and phase tables of the bridge duty generator.
package tpbd_pkg;

	localparam int unsigned DATA_W    = 16;
	localparam int unsigned PHASES    = 3;
	localparam int unsigned DIV_STEPS = 16;

	localparam logic [1:0] ACT_PHASE = 2'd0;
	localparam logic [1:0] ACT_STEP  = 2'd1;
	localparam logic [1:0] ACT_FREE  = 2'd2;

	localparam logic [1:0] CFG_SPAN   = 2'd0;
	localparam logic [1:0] CFG_PERIOD = 2'd1;
	localparam logic [1:0] CFG_LOW_ON = 2'd2;

	localparam logic [DATA_W-1:0] RESET_SPAN   = 16'd1000;
	localparam logic [DATA_W-1:0] RESET_PERIOD = 16'd1000;
	localparam logic [DATA_W-1:0] RESET_LOW_ON = 16'd1000;
	localparam logic [DATA_W-1:0] DUTY_SAT     = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_PHASE,
		KIND_STEP,
		KIND_FREE
	} kind_t;

	typedef struct packed {
		kind_t                         kind;
		logic [2:0]                    step;
		logic [PHASES-1:0][DATA_W-1:0] v;
	} cmd_t;

	function automatic logic [1:0] driven_phase(input logic [2:0] step);
		logic [1:0] p;
		case (step)
			3'd0, 3'd1: p = 2'd0;
			3'd2, 3'd3: p = 2'd1;
			3'd4, 3'd5: p = 2'd2;
			default:    p = 2'd0;
		endcase
		return p;
	endfunction

	function automatic logic [1:0] low_on_phase(input logic [2:0] step);
		logic [1:0] p;
		case (step)
			3'd0:    p = 2'd2;
			3'd1:    p = 2'd1;
			3'd2:    p = 2'd0;
			3'd3:    p = 2'd2;
			3'd4:    p = 2'd1;
			3'd5:    p = 2'd0;
			default: p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/three_phase_bridge_duty_generator.sv =====
// Top level of the three-phase bridge duty generator.
// A command is taken on start while busy is low and lands in a short queue, so a new
// command can follow in the next cycle while an earlier one is still being worked on.
// Phase-voltage and six-step commands pass in order through the queue pop, the three
// 16x16 multipliers, the divider set-up and the one-bit-per-cycle division by the
// supply span, which sets the sustained rate. Freewheel commands finish in the cycle
// after the pop. Each result is shown for exactly one cycle with done high; the
// receiver cannot stall, so it must take the transfer in that cycle. Configuration
// must be written only while no command is in flight; the block does not enforce it.
module three_phase_bridge_duty_generator #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic signed [15:0] phase_a_voltage,
	input  logic signed [15:0] phase_b_voltage,
	input  logic signed [15:0] phase_c_voltage,
	input  logic [15:0]        step_voltage,
	input  logic [15:0]        commutation_step,
	output logic               done,
	output logic [15:0]        high_a_compare,
	output logic [15:0]        low_a_compare,
	output logic [15:0]        high_b_compare,
	output logic [15:0]        low_b_compare,
	output logic [15:0]        high_c_compare,
	output logic [15:0]        low_c_compare
);

	logic [15:0]    span_q;
	logic [15:0]    period_q;
	logic [15:0]    low_on_q;
	tpbd_pkg::cmd_t front_cmd;
	tpbd_pkg::cmd_t q_head;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic           accept;

	assign busy   = q_full;
	assign accept = start && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q   <= tpbd_pkg::RESET_SPAN;
			period_q <= tpbd_pkg::RESET_PERIOD;
			low_on_q <= tpbd_pkg::RESET_LOW_ON;
		end else if (cfg_we) begin
			case (cfg_index)
				tpbd_pkg::CFG_SPAN:   span_q   <= cfg_data;
				tpbd_pkg::CFG_PERIOD: period_q <= cfg_data;
				tpbd_pkg::CFG_LOW_ON: low_on_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tpbd_front u_front (
		.action           (action),
		.phase_a_voltage  (phase_a_voltage),
		.phase_b_voltage  (phase_b_voltage),
		.phase_c_voltage  (phase_c_voltage),
		.step_voltage     (step_voltage),
		.commutation_step (commutation_step),
		.supply_span      (span_q),
		.cmd              (front_cmd)
	);

	tpbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (front_cmd),
		.pop    (q_pop),
		.dout   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	tpbd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.supply_span    (span_q),
		.pwm_period     (period_q),
		.low_on_compare (low_on_q),
		.done           (done),
		.high_a_compare (high_a_compare),
		.low_a_compare  (low_a_compare),
		.high_b_compare (high_b_compare),
		.low_b_compare  (low_b_compare),
		.high_c_compare (high_c_compare),
		.low_c_compare  (low_c_compare)
	);

	`include "three_phase_bridge_duty_generator_macros.svh"

	`TPBD_ASSERT_NEXT(a_accept_queued, accept, !q_empty)
	`TPBD_ASSERT_SAME(a_pop_needs_entry, q_pop, !q_empty)
	`TPBD_ASSERT_SAME(a_result_held, !done, $stable(high_a_compare) && $stable(low_c_compare))

endmodule

// ===== rtl/tpbd_front.sv =====
// Command front end: decodes the action, clamps phase voltages and reduces the step modulo six.
module tpbd_front (
	input  logic [1:0]         action,
	input  logic signed [15:0] phase_a_voltage,
	input  logic signed [15:0] phase_b_voltage,
	input  logic signed [15:0] phase_c_voltage,
	input  logic [15:0]        step_voltage,
	input  logic [15:0]        commutation_step,
	input  logic [15:0]        supply_span,
	output tpbd_pkg::cmd_t     cmd
);

	function automatic logic [15:0] clamp_phase(input logic signed [15:0] volt,
	                                            input logic [15:0] maxv);
		logic signed [17:0] sum;
		logic [15:0]        res;
		sum = 18'(volt) + $signed({3'b000, maxv[15:1]});
		if (sum < 18'sd0) begin
			res = 16'd0;
		end else if (sum > $signed({2'b00, maxv})) begin
			res = maxv;
		end else begin
			res = sum[15:0];
		end
		return res;
	endfunction

	// Residue modulo three from the base-four digit sum, then fixed by parity.
	function automatic logic [2:0] mod_six(input logic [15:0] x);
		logic [4:0] s;
		logic [2:0] r;
		s = 5'd0;
		for (int i = 0; i < 8; i++) begin
			s = s + {3'b000, x[2*i +: 2]};
		end
		if (s >= 5'd24) begin
			s = s - 5'd24;
		end
		if (s >= 5'd12) begin
			s = s - 5'd12;
		end
		if (s >= 5'd6) begin
			s = s - 5'd6;
		end
		if (s >= 5'd3) begin
			s = s - 5'd3;
		end
		r = s[2:0];
		if (r[0] != x[0]) begin
			r = r + 3'd3;
		end
		return r;
	endfunction

	always_comb begin
		cmd.step = mod_six(commutation_step);
		cmd.v    = '0;
		case (action)
			tpbd_pkg::ACT_PHASE: begin
				cmd.kind = tpbd_pkg::KIND_PHASE;
				cmd.v[0] = clamp_phase(phase_a_voltage, supply_span);
				cmd.v[1] = clamp_phase(phase_b_voltage, supply_span);
				cmd.v[2] = clamp_phase(phase_c_voltage, supply_span);
			end
			tpbd_pkg::ACT_STEP: begin
				cmd.kind = tpbd_pkg::KIND_STEP;
				cmd.v[0] = step_voltage;
			end
			default: begin
				cmd.kind = tpbd_pkg::KIND_FREE;
			end
		endcase
	end

endmodule

// ===== rtl/tpbd_queue.sv =====
// Small register queue between the command front end and the duty back end.
module tpbd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tpbd_pkg::cmd_t din,
	input  logic           pop,
	output tpbd_pkg::cmd_t dout,
	output logic           full,
	output logic           empty
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tpbd_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/tpbd_back.sv =====
// Duty back end: scales by the PWM period, divides by the supply span bit by bit and builds the result.
module tpbd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  tpbd_pkg::cmd_t q_head,
	output logic           q_pop,
	input  logic [15:0]    supply_span,
	input  logic [15:0]    pwm_period,
	input  logic [15:0]    low_on_compare,
	output logic           done,
	output logic [15:0]    high_a_compare,
	output logic [15:0]    low_a_compare,
	output logic [15:0]    high_b_compare,
	output logic [15:0]    low_b_compare,
	output logic [15:0]    high_c_compare,
	output logic [15:0]    low_c_compare
);

	localparam int unsigned PH = tpbd_pkg::PHASES;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV
	} state_t;

	state_t          state_q;
	tpbd_pkg::cmd_t  cmd_q;
	logic [31:0]     prod_s1 [PH];
	logic [15:0]     rem_q   [PH];
	logic [15:0]     quo_q   [PH];
	logic [PH-1:0]   sat_q;
	logic [3:0]      cnt_q;
	logic            done_q;
	logic [15:0]     hi_q    [PH];
	logic [15:0]     lo_q    [PH];

	logic [15:0]     rem_next [PH];
	logic [15:0]     quo_next [PH];
	logic [15:0]     duty     [PH];
	logic [15:0]     hi_next  [PH];
	logic [15:0]     lo_next  [PH];
	logic [1:0]      dp;
	logic [1:0]      lp;

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	always_comb begin
		for (int i = 0; i < PH; i++) begin
			logic [16:0] r2;
			logic        ge;
			r2 = {rem_q[i], quo_q[i][15]};
			ge = (r2 >= {1'b0, supply_span});
			rem_next[i] = ge ? 16'(r2 - {1'b0, supply_span}) : r2[15:0];
			quo_next[i] = {quo_q[i][14:0], ge};
			if (supply_span == '0) begin
				duty[i] = '0;
			end else if (sat_q[i]) begin
				duty[i] = tpbd_pkg::DUTY_SAT;
			end else begin
				duty[i] = quo_next[i];
			end
		end
	end

	always_comb begin
		dp = tpbd_pkg::driven_phase(cmd_q.step);
		lp = tpbd_pkg::low_on_phase(cmd_q.step);
		for (int i = 0; i < PH; i++) begin
			if (cmd_q.kind == tpbd_pkg::KIND_STEP) begin
				hi_next[i] = (dp == 2'(i)) ? duty[0] : '0;
				lo_next[i] = (lp == 2'(i)) ? low_on_compare :
				             (dp == 2'(i)) ? duty[0] : '0;
			end else begin
				hi_next[i] = duty[i];
				lo_next[i] = duty[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < PH; i++) begin
			prod_s1[i] <= 32'(cmd_q.v[i]) * 32'(pwm_period);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			sat_q   <= '0;
			cmd_q   <= '0;
			for (int i = 0; i < PH; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
				hi_q[i]  <= '0;
				lo_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					done_q <= !q_empty && (q_head.kind == tpbd_pkg::KIND_FREE);
					if (!q_empty) begin
						cmd_q <= q_head;
						if (q_head.kind == tpbd_pkg::KIND_FREE) begin
							for (int i = 0; i < PH; i++) begin
								hi_q[i] <= '0;
								lo_q[i] <= pwm_period;
							end
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					done_q  <= 1'b0;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					done_q <= 1'b0;
					for (int i = 0; i < PH; i++) begin
						rem_q[i] <= prod_s1[i][31:16];
						quo_q[i] <= prod_s1[i][15:0];
						sat_q[i] <= (prod_s1[i][31:16] >= supply_span);
					end
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					done_q <= (cnt_q == 4'(tpbd_pkg::DIV_STEPS - 1));
					for (int i = 0; i < PH; i++) begin
						rem_q[i] <= rem_next[i];
						quo_q[i] <= quo_next[i];
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'(tpbd_pkg::DIV_STEPS - 1)) begin
						for (int i = 0; i < PH; i++) begin
							hi_q[i] <= hi_next[i];
							lo_q[i] <= lo_next[i];
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign high_a_compare = hi_q[0];
	assign low_a_compare  = lo_q[0];
	assign high_b_compare = hi_q[1];
	assign low_b_compare  = lo_q[1];
	assign high_c_compare = hi_q[2];
	assign low_c_compare  = lo_q[2];

endmodule

// ===== dv/tpbd_compare_checker.sv =====
// Checker for the bridge duty generator: tracks the registers, predicts every result and compares it.
module tpbd_compare_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         action,
	input  logic signed [15:0] phase_a_voltage,
	input  logic signed [15:0] phase_b_voltage,
	input  logic signed [15:0] phase_c_voltage,
	input  logic [15:0]        step_voltage,
	input  logic [15:0]        commutation_step,
	input  logic               done,
	input  logic [15:0]        high_a_compare,
	input  logic [15:0]        low_a_compare,
	input  logic [15:0]        high_b_compare,
	input  logic [15:0]        low_b_compare,
	input  logic [15:0]        high_c_compare,
	input  logic [15:0]        low_c_compare,
	output int                 errors,
	output int                 results_checked,
	output int                 outstanding
);

	localparam int REPORT_LIMIT = 10;

	typedef logic [5:0][15:0] compare_set_t;

	logic [15:0] span_reg;
	logic [15:0] period_reg;
	logic [15:0] low_on_reg;
	compare_set_t expected_compares_q[$];

	function automatic logic [15:0] scale_to_period(input longint unsigned level);
		longint unsigned quotient;
		if (span_reg == 16'd0)
			return 16'd0;
		quotient = level * period_reg / span_reg;
		return (quotient > 64'hFFFF) ? tpbd_pkg::DUTY_SAT : quotient[15:0];
	endfunction

	function automatic compare_set_t predict_compares(input logic [1:0] act,
			input logic [2:0][15:0] volts, input logic [15:0] step_v,
			input logic [15:0] position);
		compare_set_t r;
		longint level;
		logic [15:0] duty;
		int sector;
		int drive_ph;
		int return_ph;
		r = '0;
		case (act)
			tpbd_pkg::ACT_PHASE: begin
				for (int ph = 0; ph < 3; ph++) begin
					level = longint'($signed(volts[ph])) + longint'(span_reg >> 1);
					if (level < 0)
						level = 0;
					else if (level > longint'(span_reg))
						level = longint'(span_reg);
					duty = scale_to_period(unsigned'(level));
					r[2*ph] = duty;
					r[2*ph+1] = duty;
				end
			end
			tpbd_pkg::ACT_STEP: begin
				sector = int'(position) % 6;
				duty = scale_to_period(64'(step_v));
				case (sector)
					0: begin drive_ph = 0; return_ph = 2; end
					1: begin drive_ph = 0; return_ph = 1; end
					2: begin drive_ph = 1; return_ph = 0; end
					3: begin drive_ph = 1; return_ph = 2; end
					4: begin drive_ph = 2; return_ph = 1; end
					default: begin drive_ph = 2; return_ph = 0; end
				endcase
				r[2*drive_ph] = duty;
				r[2*drive_ph+1] = duty;
				r[2*return_ph+1] = low_on_reg;
			end
			default: begin
				for (int ph = 0; ph < 3; ph++) begin
					r[2*ph] = 16'd0;
					r[2*ph+1] = period_reg;
				end
			end
		endcase
		return r;
	endfunction

	function automatic string compare_name(input int idx);
		case (idx)
			0: return "high_a_compare";
			1: return "low_a_compare";
			2: return "high_b_compare";
			3: return "low_b_compare";
			4: return "high_c_compare";
			default: return "low_c_compare";
		endcase
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%0t compare_check: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_ports
		compare_set_t seen;
		compare_set_t want;
		if (!arst_n) begin
			span_reg <= tpbd_pkg::RESET_SPAN;
			period_reg <= tpbd_pkg::RESET_PERIOD;
			low_on_reg <= tpbd_pkg::RESET_LOW_ON;
			expected_compares_q.delete();
			errors = 0;
			results_checked = 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				seen = {low_c_compare, high_c_compare, low_b_compare, high_b_compare,
					low_a_compare, high_a_compare};
				if (expected_compares_q.size() == 0) begin
					flag_error("result transfer with no command outstanding");
				end else begin
					want = expected_compares_q.pop_front();
					results_checked++;
					for (int f = 0; f < 6; f++) begin
						if (seen[f] !== want[f])
							flag_error($sformatf("%s expected %0d got %0d",
								compare_name(f), want[f], seen[f]));
					end
				end
			end
			if (start && !busy)
				expected_compares_q.push_back(predict_compares(action,
					{phase_c_voltage, phase_b_voltage, phase_a_voltage},
					step_voltage, commutation_step));
			if (cfg_we) begin
				case (cfg_index)
					tpbd_pkg::CFG_SPAN:   span_reg <= cfg_data;
					tpbd_pkg::CFG_PERIOD: period_reg <= cfg_data;
					tpbd_pkg::CFG_LOW_ON: low_on_reg <= cfg_data;
					default:              ;
				endcase
			end
			outstanding <= expected_compares_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Top of the bridge duty generator testbench: clock, reset, command and register stimulus, verdict.
module tb_top;

	localparam logic [1:0] ACT_FREE_ALT = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETUP_COUNT = 8;
	localparam int ITEMS_PER_SETUP = 175;
	localparam int RANDOM_ITEMS = SETUP_COUNT * ITEMS_PER_SETUP;
	localparam int TAIL_CYCLES = 40;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = tpbd_pkg::CFG_SPAN;
	logic [15:0]        cfg_data = '0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         action = tpbd_pkg::ACT_PHASE;
	logic signed [15:0] phase_a_voltage = '0;
	logic signed [15:0] phase_b_voltage = '0;
	logic signed [15:0] phase_c_voltage = '0;
	logic [15:0]        step_voltage = '0;
	logic [15:0]        commutation_step = '0;
	logic               done;
	logic [15:0]        high_a_compare;
	logic [15:0]        low_a_compare;
	logic [15:0]        high_b_compare;
	logic [15:0]        low_b_compare;
	logic [15:0]        high_c_compare;
	logic [15:0]        low_c_compare;

	int errors;
	int results_checked;
	int outstanding;
	int idle_pct = 0;
	int commands_sent = 0;
	int setups_applied = 0;
	int quiet_cycles = 0;
	logic [15:0] span = tpbd_pkg::RESET_SPAN;

	three_phase_bridge_duty_generator dut (.*);

	tpbd_compare_checker compare_check (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles.", WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_command(input logic [1:0] act, input logic [15:0] va,
			input logic [15:0] vb, input logic [15:0] vc, input logic [15:0] sv,
			input logic [15:0] cs);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		phase_a_voltage <= va;
		phase_b_voltage <= vb;
		phase_c_voltage <= vc;
		step_voltage <= sv;
		commutation_step <= cs;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		commands_sent++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic apply_setup(input logic [15:0] mv, input logic [15:0] md,
			input logic [15:0] lo);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= tpbd_pkg::CFG_SPAN;
		cfg_data <= mv;
		@(posedge clk);
		cfg_index <= tpbd_pkg::CFG_PERIOD;
		cfg_data <= md;
		@(posedge clk);
		cfg_index <= tpbd_pkg::CFG_LOW_ON;
		cfg_data <= lo;
		@(posedge clk);
		cfg_we <= 1'b0;
		span = mv;
		setups_applied++;
	endtask

	function automatic logic [1:0] pick_action();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return tpbd_pkg::ACT_PHASE;
		if (r < 80)
			return tpbd_pkg::ACT_STEP;
		if (r < 95)
			return tpbd_pkg::ACT_FREE;
		return ACT_FREE_ALT;
	endfunction

	function automatic logic [15:0] pick_voltage();
		int lim;
		if ($urandom_range(1) == 1)
			return 16'($urandom);
		lim = int'(span) / 2 + 2;
		return 16'(int'($urandom_range(2 * lim)) - lim);
	endfunction

	function automatic logic [15:0] pick_step_voltage();
		if ($urandom_range(1) == 1)
			return 16'($urandom);
		return 16'($urandom_range(int'(span) + 4));
	endfunction

	function automatic logic [15:0] pick_position();
		if ($urandom_range(3) == 0)
			return 16'($urandom_range(11));
		return 16'($urandom);
	endfunction

	initial begin
		int item_no;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(tpbd_pkg::ACT_PHASE, 16'd0, 16'd0, 16'd0, 16'($urandom),
			16'($urandom));
		send_command(tpbd_pkg::ACT_PHASE, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'd0);
		send_command(tpbd_pkg::ACT_PHASE, -16'sd500, 16'd500, 16'd499, 16'hFFFF, 16'hFFFF);
		send_command(tpbd_pkg::ACT_PHASE, -16'sd501, 16'd501, -16'sd499, 16'd0, 16'd0);
		send_command(tpbd_pkg::ACT_STEP, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd600, 16'd0);
		send_command(tpbd_pkg::ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd600, 16'd1);
		send_command(tpbd_pkg::ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd600, 16'd2);
		send_command(tpbd_pkg::ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd600, 16'd3);
		send_command(tpbd_pkg::ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd600, 16'd10);
		send_command(tpbd_pkg::ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd600, 16'd5);
		send_command(tpbd_pkg::ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd600, 16'hFFFF);
		send_command(tpbd_pkg::ACT_STEP, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0);
		send_command(tpbd_pkg::ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4);
		send_command(tpbd_pkg::ACT_FREE, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
		send_command(ACT_FREE_ALT, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));

		apply_setup(16'd0, 16'd1234, 16'd77);
		send_command(tpbd_pkg::ACT_PHASE, 16'd100, -16'sd100, 16'd0, 16'd0, 16'd0);
		send_command(tpbd_pkg::ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd500, 16'd1);
		send_command(tpbd_pkg::ACT_FREE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);

		apply_setup(16'd1, 16'hFFFF, 16'd0);
		send_command(tpbd_pkg::ACT_STEP, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd2);
		send_command(tpbd_pkg::ACT_STEP, 16'd0, 16'd0, 16'd0, 16'd1, 16'd5);
		send_command(tpbd_pkg::ACT_PHASE, 16'd0, 16'd1, -16'sd1, 16'd0, 16'd0);

		for (int s = 0; s < SETUP_COUNT; s++) begin
			case (s)
				0: apply_setup(16'hFFFF, 16'hFFFF, 16'hFFFF);
				1: apply_setup(16'd1, 16'd1, 16'd0);
				2: apply_setup(16'd1, 16'hFFFF, 16'hFFFF);
				3: apply_setup(16'hFFFF, 16'd1, 16'd0);
				4: apply_setup(16'd0, 16'($urandom), 16'($urandom));
				7: apply_setup(16'($urandom), 16'($urandom), 16'($urandom));
				default: apply_setup(16'($urandom_range(2, 4000)), 16'($urandom),
					16'($urandom));
			endcase
			for (int k = 0; k < ITEMS_PER_SETUP; k++) begin
				item_no = s * ITEMS_PER_SETUP + k;
				if (item_no < RANDOM_ITEMS / 3)
					idle_pct = 7;
				else if (item_no < 2 * RANDOM_ITEMS / 3)
					idle_pct = 74;
				else
					idle_pct = 0;
				send_command(pick_action(), pick_voltage(), pick_voltage(), pick_voltage(),
					pick_step_voltage(), pick_position());
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d commands under %0d register setups, %0d results compared.",
			commands_sent, setups_applied, results_checked);
		$display("Setups spanned zero and full span, saturating duty and light to heavy gaps.");
		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
